>>> src/evad_pkg.sv
// ----------------------------------------------------------------------------
// evad_pkg: shared types and constants of the energy voice activity detector
// Widths, window geometry and register index codes used by all modules.
// ----------------------------------------------------------------------------
package evad_pkg;

   localparam int WINDOW            = 16;
   localparam int MAX_FRAME_SAMPLES = 4096;

   localparam int SAMPLE_W = 16;
   localparam int NOW_W    = 32;
   localparam int ENERGY_W = 16;
   localparam int THR_W    = 16;
   localparam int STOP_W   = 9;
   localparam int HOLD_W   = 32;
   localparam int FRAME_W  = 13;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;

   localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam int SUM_W  = $clog2(MAX_FRAME_SAMPLES) + SAMPLE_W;
   localparam int CMP_W  = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int ROT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int NEED_W = (FILL_W > STOP_W) ? FILL_W : STOP_W;
   localparam int START_NEED = (WINDOW / 2 < 1) ? 1 : WINDOW / 2;
   localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

   localparam int REQ_DATA_W = SAMPLE_W + NOW_W;
   localparam int RSP_DATA_W = ((ENERGY_W + 4 + 7) / 8) * 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD  = 2'd0,
      CSR_STOP_COUNT = 2'd1,
      CSR_HOLDOFF    = 2'd2,
      CSR_FRAME_LEN  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_COUNT,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic                     done;
      logic [ENERGY_W-1:0]      quotient;
   } div_result_type;

endpackage

>>> src/energy_voice_activity_detector_core.sv
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_core: energy based voice activity detector
// Frame energy from PCM magnitudes, windowed voice decision, start/stop events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one PCM word per handshake; tdata = {now_ms, sample}.
//   rsp_*  : one word per frame; tdata = {pad, stopped, started, capture,
//            recording, frame_energy}.
//   csr_*  : register writes, index 0 threshold, 1 stop count, 2 holdoff,
//            3 frame length. Write only while idle.
// Throughput: samples inside a frame take 1 cycle each. The last sample of
//   a frame starts the serial divider; once the window is full, the window
//   cells are then rotated past the counter, then a decide step issues the
//   result word. No new sample is taken until the decide step is done. The
//   serial divider and the window rotation set the cost of a frame end.
// Reset clears the sample count and sum, flags, window fill and loads default registers.
// A stalled receiver holds one result word; samples of the next frame are
//   still taken, and the block waits at the next frame end until it drains.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [evad_pkg::REQ_DATA_W-1:0]   req_tdata,  // sample, now_ms
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [evad_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // frame_energy, recording,
                                                         // capture, started, stopped
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  evad_pkg::csr_index_type           csr_index,
   input  logic [evad_pkg::CSR_W-1:0]        csr_data
);
   import evad_pkg::*;

   state_type            state_ff, state_in;
   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [STOP_W-1:0]    stop_ff, stop_in;
   logic [HOLD_W-1:0]    hold_ff, hold_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [NOW_W-1:0]     now_ff, now_in;
   logic [ENERGY_W-1:0]  energy_ff, energy_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [ROT_W-1:0]     rot_ff, rot_in;
   logic [FILL_W-1:0]    above_ff, above_in;
   logic                 rec_ff, rec_in;
   logic                 ins_ff, ins_in;
   logic [NOW_W-1:0]     stop_time_ff, stop_time_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ENERGY_W-1:0]  rsp_energy_ff, rsp_energy_in;
   logic                 rsp_rec_ff, rsp_rec_in;
   logic                 rsp_cap_ff, rsp_cap_in;
   logic                 rsp_start_ff, rsp_start_in;
   logic                 rsp_stop_ff, rsp_stop_in;

   logic [SAMPLE_W-1:0]  sample;
   logic [SAMPLE_W-1:0]  mag;
   logic [SUM_W-1:0]     sum_next;
   logic [CNT_W-1:0]     cnt_next;
   logic [CMP_W-1:0]     frame_len;
   logic                 frame_end;
   logic                 req_fire;
   logic                 div_start;
   div_result_type       div_res;
   logic                 shift;
   logic [ENERGY_W-1:0]  head_energy;
   logic [ENERGY_W-1:0]  cell_energy [WINDOW];
   logic                 cell_above  [WINDOW];
   logic [STOP_W-1:0]    stop_need;
   logic [NOW_W-1:0]     elapsed;
   logic                 window_full;

   assign sample    = req_tdata[SAMPLE_W-1:0];
   assign mag       = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
   assign sum_next  = sum_ff + SUM_W'(mag);
   assign cnt_next  = cnt_ff + 1'b1;
   assign req_tready = (state_ff == ST_ACCUM);
   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_comb begin
      if (frame_ff == '0) begin
         frame_len = CMP_W'(1);
      end else if (CMP_W'(frame_ff) > CMP_W'(MAX_FRAME_SAMPLES)) begin
         frame_len = CMP_W'(MAX_FRAME_SAMPLES);
      end else begin
         frame_len = CMP_W'(frame_ff);
      end
   end

   assign frame_end = CMP_W'(cnt_next) >= frame_len;
   assign div_start = req_fire && frame_end;

   evad_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_next),
      .divisor  (cnt_next),
      .result   (div_res)
   );

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      evad_cell u_cell (
         .clock       (clock),
         .shift       (shift),
         .energy_prev ((i == 0) ? head_energy : cell_energy[(i + WINDOW - 1) % WINDOW]),
         .threshold   (thr_ff),
         .energy_out  (cell_energy[i]),
         .above       (cell_above[i])
      );
   end

   assign stop_need   = (stop_ff == '0) ? STOP_W'(1) : stop_ff;
   assign elapsed     = now_ff - stop_time_ff;
   assign window_full = (fill_ff == FILL_W'(WINDOW));

   always_comb begin
      state_in      = state_ff;
      thr_in        = thr_ff;
      stop_in       = stop_ff;
      hold_in       = hold_ff;
      frame_in      = frame_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      now_in        = now_ff;
      energy_in     = energy_ff;
      fill_in       = fill_ff;
      rot_in        = rot_ff;
      above_in      = above_ff;
      rec_in        = rec_ff;
      ins_in        = ins_ff;
      stop_time_in  = stop_time_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_energy_in = rsp_energy_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_cap_in    = rsp_cap_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_stop_in   = rsp_stop_ff;
      shift         = 1'b0;
      head_energy   = cell_energy[WINDOW-1];

      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD:  thr_in   = csr_data[THR_W-1:0];
            CSR_STOP_COUNT: stop_in  = csr_data[STOP_W-1:0];
            CSR_HOLDOFF:    hold_in  = csr_data[HOLD_W-1:0];
            CSR_FRAME_LEN:  frame_in = csr_data[FRAME_W-1:0];
            default:        thr_in   = thr_ff;
         endcase
      end

      case (state_ff)
         ST_ACCUM: begin
            if (req_fire) begin
               if (frame_end) begin
                  cnt_in   = '0;
                  sum_in   = '0;
                  now_in   = req_tdata[SAMPLE_W +: NOW_W];
                  state_in = ST_DIVIDE;
               end else begin
                  cnt_in = cnt_next;
                  sum_in = sum_next;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_res.done) begin
               energy_in   = div_res.quotient;
               head_energy = div_res.quotient;
               shift       = 1'b1;
               rot_in      = '0;
               above_in    = '0;
               if (fill_ff != FILL_W'(WINDOW)) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (fill_ff >= FILL_W'(WINDOW - 1)) begin
                  state_in = ST_COUNT;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_COUNT: begin
            shift    = 1'b1;
            above_in = above_ff + FILL_W'(cell_above[WINDOW-1]);
            rot_in   = rot_ff + 1'b1;
            if (rot_ff == ROT_W'(WINDOW - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_start_in = 1'b0;
               rsp_stop_in  = 1'b0;
               if (window_full) begin
                  if (rec_ff) begin
                     if (NEED_W'(above_ff) < NEED_W'(stop_need) && elapsed > hold_ff) begin
                        stop_time_in = now_ff;
                        rec_in       = 1'b0;
                        ins_in       = 1'b0;
                        rsp_stop_in  = 1'b1;
                     end
                  end else if (energy_ff > thr_ff) begin
                     if (above_ff >= FILL_W'(START_NEED)) begin
                        rec_in       = 1'b1;
                        ins_in       = 1'b1;
                        rsp_start_in = 1'b1;
                     end
                  end else begin
                     ins_in = 1'b1;
                  end
               end
               rsp_valid_in  = 1'b1;
               rsp_energy_in = energy_ff;
               rsp_rec_in    = rec_in;
               rsp_cap_in    = rec_in || ins_in;
               state_in      = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         thr_ff       <= THR_W'(1638);
         stop_ff      <= STOP_W'(8);
         hold_ff      <= HOLD_W'(1000);
         frame_ff     <= FRAME_W'(1024);
         cnt_ff       <= '0;
         sum_ff       <= '0;
         fill_ff      <= '0;
         rec_ff       <= 1'b0;
         ins_ff       <= 1'b0;
         stop_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         stop_ff      <= stop_in;
         hold_ff      <= hold_in;
         frame_ff     <= frame_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         rec_ff       <= rec_in;
         ins_ff       <= ins_in;
         stop_time_ff <= stop_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff        <= now_in;
      energy_ff     <= energy_in;
      rot_ff        <= rot_in;
      above_ff      <= above_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_cap_ff    <= rsp_cap_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_stop_ff   <= rsp_stop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_stop_ff, rsp_start_ff, rsp_cap_ff,
                                    rsp_rec_ff, rsp_energy_ff});

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW))
      else $error("window fill beyond window size");

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide phase");

   a_start_stop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_start_ff && rsp_stop_ff))
      else $error("start and stop on one frame");

   a_rec_capture: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rec_ff) |-> rsp_cap_ff)
      else $error("recording word without capture");

   a_above_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE && window_full |-> above_ff <= FILL_W'(WINDOW))
      else $error("window count out of range");

endmodule

>>> src/evad_cell.sv
// ----------------------------------------------------------------------------
// evad_cell: one entry of the frame energy window
// Holds one energy, passes it to the next cell on shift, flags voice level.
// ----------------------------------------------------------------------------
module evad_cell (
   input  logic                           clock,
   input  logic                           shift,
   input  logic [evad_pkg::ENERGY_W-1:0]  energy_prev,
   input  logic [evad_pkg::THR_W-1:0]     threshold,
   output logic [evad_pkg::ENERGY_W-1:0]  energy_out,
   output logic                           above
);
   import evad_pkg::*;

   logic [ENERGY_W-1:0] energy_ff;
   logic [ENERGY_W-1:0] energy_in;

   assign energy_in = shift ? energy_prev : energy_ff;

   always_ff @(posedge clock) begin
      energy_ff <= energy_in;
   end

   assign energy_out = energy_ff;
   assign above      = energy_ff > threshold;

endmodule

>>> src/evad_divider.sv
// ----------------------------------------------------------------------------
// evad_divider: restoring divider for the frame mean
// One quotient bit per cycle while busy; magnitude sum over sample count.
// ----------------------------------------------------------------------------
module evad_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [evad_pkg::SUM_W-1:0]   dividend,
   input  logic [evad_pkg::CNT_W-1:0]   divisor,
   output evad_pkg::div_result_type     result
);
   import evad_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [SUM_W-1:0]  quot_ff, quot_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quot_in = quot_ff;
      trial   = {rem_ff, quot_ff[SUM_W-1]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W - 1);
         rem_in  = '0;
         div_in  = divisor;
         quot_in = dividend;
      end else if (busy_ff) begin
         if (!diff[CNT_W]) begin
            rem_in  = diff[CNT_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[CNT_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quot_ff[ENERGY_W-1:0];

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the energy voice activity detector core
// PCM words go in on the request stream and frame words come back on the
// response stream. A scoreboard class predicts frame energy, the window
// decision, the capture flag and the start/stop events. Each returned word
// is checked against the oldest prediction. The run has a short directed
// start/stop sequence, then random phases over register settings, sender and
// receiver idling and one long receiver hold-off, and ends with a partial
// frame at a frame length above the maximum that is cut short by lowering
// the frame length.
// ----------------------------------------------------------------------------
import evad_pkg::*;

typedef struct packed {
   logic                stopped;
   logic                started;
   logic                capture;
   logic                recording;
   logic [ENERGY_W-1:0] energy;
} frame_verdict_type;

class voice_frame_checker;
   logic [THR_W-1:0]    thr;
   logic [STOP_W-1:0]   stop_cnt;
   logic [HOLD_W-1:0]   holdoff;
   logic [FRAME_W-1:0]  frame_len;
   int unsigned         samples_in_frame;
   int unsigned         magnitude_total;
   logic [ENERGY_W-1:0] window_energy [WINDOW];
   int unsigned         write_slot;
   int unsigned         window_count;
   bit                  recording;
   bit                  keep_preroll;
   logic [NOW_W-1:0]    last_stop_ms;
   frame_verdict_type   expected_frames [$];
   int unsigned         errors;
   int unsigned         frames_seen;
   int unsigned         samples_seen;
   int unsigned         starts_seen;
   int unsigned         stops_seen;

   function new();
      thr = 16'd1638;
      stop_cnt = 9'd8;
      holdoff = 32'd1000;
      frame_len = 13'd1024;
      samples_in_frame = 0;
      magnitude_total = 0;
      foreach (window_energy[i]) window_energy[i] = '0;
      write_slot = 0;
      window_count = 0;
      recording = 0;
      keep_preroll = 0;
      last_stop_ms = '0;
      errors = 0;
      frames_seen = 0;
      samples_seen = 0;
      starts_seen = 0;
      stops_seen = 0;
   endfunction

   function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endfunction

   function void write_reg(csr_index_type idx, logic [CSR_W-1:0] d);
      case (idx)
         CSR_THRESHOLD:  thr = d[THR_W-1:0];
         CSR_STOP_COUNT: stop_cnt = d[STOP_W-1:0];
         CSR_HOLDOFF:    holdoff = d[HOLD_W-1:0];
         CSR_FRAME_LEN:  frame_len = d[FRAME_W-1:0];
         default: ;
      endcase
   endfunction

   function void take_sample(logic [SAMPLE_W-1:0] raw, logic [NOW_W-1:0] now);
      int unsigned         mag;
      int unsigned         limit;
      int unsigned         above;
      int unsigned         need;
      logic [ENERGY_W-1:0] energy;
      logic [NOW_W-1:0]    elapsed;
      frame_verdict_type   v;
      samples_seen++;
      mag = raw[SAMPLE_W-1] ? 32'h10000 - 32'(raw) : 32'(raw);
      magnitude_total += mag;
      samples_in_frame++;
      limit = (frame_len == 0) ? 1 :
              (frame_len > MAX_FRAME_SAMPLES) ? MAX_FRAME_SAMPLES : 32'(frame_len);
      if (samples_in_frame < limit) return;

      energy = ENERGY_W'(magnitude_total / samples_in_frame);
      samples_in_frame = 0;
      magnitude_total = 0;
      window_energy[write_slot] = energy;
      write_slot = (write_slot + 1) % WINDOW;
      if (window_count < WINDOW) window_count++;

      v = '0;
      if (window_count == WINDOW) begin
         above = 0;
         foreach (window_energy[i]) if (window_energy[i] > thr) above++;
         if (recording) begin
            need = (stop_cnt == 0) ? 1 : 32'(stop_cnt);
            elapsed = now - last_stop_ms;
            if (above < need && elapsed > holdoff) begin
               last_stop_ms = now;
               recording = 0;
               keep_preroll = 0;
               v.stopped = 1'b1;
               stops_seen++;
            end
         end else if (energy > thr) begin
            if (above >= START_NEED) begin
               recording = 1;
               keep_preroll = 1;
               v.started = 1'b1;
               starts_seen++;
            end
         end else begin
            keep_preroll = 1;
         end
      end
      v.energy = energy;
      v.recording = recording;
      v.capture = keep_preroll || recording;
      expected_frames.push_back(v);
   endfunction

   function void compare(string field, int unsigned want, int unsigned got);
      if (want != got)
         note_error($sformatf("frame %0d %s: expected %0h, got %0h",
                              frames_seen, field, want, got));
   endfunction

   function void check_frame_word(logic [RSP_DATA_W-1:0] word);
      frame_verdict_type want;
      frame_verdict_type got;
      got = frame_verdict_type'(word[$bits(frame_verdict_type)-1:0]);
      if (expected_frames.size() == 0) begin
         note_error($sformatf("unexpected frame word %0h", word));
         return;
      end
      want = expected_frames.pop_front();
      frames_seen++;
      compare("frame_energy", 32'(want.energy), 32'(got.energy));
      compare("recording", 32'(want.recording), 32'(got.recording));
      compare("capture", 32'(want.capture), 32'(got.capture));
      compare("started", 32'(want.started), 32'(got.started));
      compare("stopped", 32'(want.stopped), 32'(got.stopped));
   endfunction
endclass

module tb_top;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 80;
   localparam int PHASES        = 14;
   localparam int TAIL_WORDS    = 200;

   // quiet run, loud run, then stop, pre-roll keep and restart
   localparam logic [SAMPLE_W-1:0] DIRECTED [19] = '{
      16'h0000, 16'h0001, 16'hFFFF, 16'h0666, 16'hF99A, 16'h00FF, 16'hFF00, 16'h03E8,
      16'h7FFF, 16'h8000, 16'h8001, 16'h0667, 16'hF999, 16'h5555, 16'hAAAA, 16'h4000,
      16'h0000, 16'h0010, 16'h2000
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_THRESHOLD;
   logic [CSR_W-1:0]      csr_data = '0;

   voice_frame_checker board = new();

   int unsigned      send_gap_pct = 0;
   int unsigned      stall_pct = 0;
   int unsigned      stall_request = 0;
   int unsigned      hold_left = 0;
   int unsigned      quiet_cycles = 0;
   logic [NOW_W-1:0] clock_ms = '0;
   bit               loud = 1'b0;

   energy_voice_activity_detector_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response side: check, then pick next ready (long hold-off has priority)
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_frame_word(rsp_tdata);
         if (stall_request != 0) begin
            hold_left = stall_request;
            stall_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d frames pending",
                     IDLE_LIMIT, board.expected_frames.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_word(logic [SAMPLE_W-1:0] s, logic [NOW_W-1:0] t);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock);
         while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {t, s};
      do @(posedge clock); while (!req_tready);
      board.take_sample(s, t);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, d);
   endtask

   // upper data bits beyond a register's width are random
   task automatic configure(logic [THR_W-1:0] thr, logic [STOP_W-1:0] stop,
                            logic [HOLD_W-1:0] hold, logic [FRAME_W-1:0] flen);
      logic [CSR_W-1:0] d;
      drain();
      d = $urandom;
      d[THR_W-1:0] = thr;
      write_reg(CSR_THRESHOLD, d);
      d = $urandom;
      d[STOP_W-1:0] = stop;
      write_reg(CSR_STOP_COUNT, d);
      write_reg(CSR_HOLDOFF, hold);
      d = $urandom;
      d[FRAME_W-1:0] = flen;
      write_reg(CSR_FRAME_LEN, d);
      csr_valid <= 1'b0;
   endtask

   // magnitude above the level when hot (32768 once the level reaches it), at or below it otherwise; some noise
   function automatic logic [SAMPLE_W-1:0] pick_sample(bit hot, logic [THR_W-1:0] level);
      int unsigned         lo;
      int unsigned         hi;
      int unsigned         m;
      logic [SAMPLE_W-1:0] s;
      if ($urandom_range(9) == 0) return SAMPLE_W'($urandom);
      lo = hot ? ((level >= 32768) ? 32768 : level + 1) : 0;
      hi = hot ? 32768 : ((level > 32768) ? 32768 : level);
      m = $urandom_range(hi, lo);
      s = SAMPLE_W'(m);
      if (m != 32768 && $urandom_range(1) == 1) s = -s;
      return s;
   endfunction

   initial begin
      logic [THR_W-1:0]   thr;
      logic [STOP_W-1:0]  stop;
      logic [HOLD_W-1:0]  hold;
      logic [FRAME_W-1:0] flen;
      int unsigned        budget;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(16'd1638, 9'd9, 32'd0, 13'd1);
      foreach (DIRECTED[i]) send_word(DIRECTED[i], 32'(i * 1000 + 7));
      clock_ms = 32'd20000;

      for (int p = 0; p < PHASES; p++) begin
         thr = THR_W'($urandom_range(5000, 300));
         stop = STOP_W'($urandom_range(12, 1));
         hold = $urandom_range(600, 0);
         flen = FRAME_W'($urandom_range(8, 1));
         case (p)
            1:  thr = 16'd0;
            2:  begin thr = 16'd32768; flen = 13'd1; end
            3:  begin stop = 9'd0; hold = 32'd0; end
            4:  stop = 9'd511;
            5:  thr = 16'hFFFF;
            6:  stop = 9'd16;
            7:  stop = 9'd17;
            8:  hold = 32'hFFFF_FFFF;
            9:  flen = 13'd0;
            10: flen = FRAME_W'($urandom_range(64, 20));
            default: ;
         endcase
         configure(thr, stop, hold, flen);
         case (p % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 58; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 58; end
            default: begin send_gap_pct = 25; stall_pct = 25; end
         endcase
         if (p == 4) stall_request = 600;
         if (p == 6) clock_ms = 32'hFFFF_F000;
         budget = $urandom_range(60, 36);
         repeat (budget) begin
            if ($urandom_range(99) < 4) loud = !loud;
            clock_ms += $urandom_range(40, 0);
            if ($urandom_range(99) < 3) clock_ms += $urandom;
            send_word(pick_sample(loud, board.thr), clock_ms);
         end
      end

      // frame length above the maximum, then lowered mid-frame: the frame
      // closes on the next word and the mean covers every word summed
      configure(board.thr, board.stop_cnt, board.holdoff, 13'h1FFF);
      send_gap_pct = 0;
      stall_pct = 0;
      repeat (TAIL_WORDS) send_word(16'h8000, clock_ms);
      configure(board.thr, board.stop_cnt, board.holdoff, 13'd1);
      send_word(16'h8000, clock_ms);
      drain();

      $display("run: %0d PCM words, %0d frame words checked, %0d starts, %0d stops",
               board.samples_seen, board.frames_seen, board.starts_seen,
               board.stops_seen);
      $display("run: %0d register phases with idling, back-pressure and %0d mismatches",
               PHASES + 3, board.errors);
      if (board.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

>>> files.f
src/evad_pkg.sv
src/evad_cell.sv
src/evad_divider.sv
src/energy_voice_activity_detector_core.sv
test/tb_top.sv
